/* design/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int CAP_W  = 11;
  localparam int DIN_W  = 16;
  localparam int ACT_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_REAR  = 3'd5
  } act_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;     // carry out the accepted action
    logic capture;  // load the memory read data into the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic peek_hit; // current action is a peek on a non-empty queue
  } dp_status_t;

endpackage

/* design/bdeq_ram.sv */
// ----------------------------------------------------------------------------
// bdeq_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdeq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/bdeq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdeq_ctrl
// Sequencer: takes one beat, waits for a peek read when needed, then holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module bdeq_ctrl
  import bdeq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t state, state_next;

  assign s_tready    = (state == ST_IDLE);
  assign m_tvalid    = (state == ST_SEND);
  assign cmd.exec    = s_tvalid && (state == ST_IDLE);
  assign cmd.capture = (state == ST_READ);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = status.peek_hit ? ST_READ : ST_SEND;
        end
      end
      ST_READ: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/bdeq_dp.sv */
// ----------------------------------------------------------------------------
// bdeq_dp
// Datapath: ring pointers, entry count, limit register, entry memory and
// the result register.
// ----------------------------------------------------------------------------
module bdeq_dp
  import bdeq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic [ACT_W-1:0] action,
  input  logic [DIN_W-1:0] data_in,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic             res_success,
  output logic [DIN_W-1:0] res_data,
  output logic             res_valid,
  output logic             res_empty,
  output logic             res_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0]    head, head_next, tail, tail_next;
  logic [CW-1:0]    count, count_next;
  logic [CAP_W-1:0] cap;

  logic [AW-1:0] head_prev, head_inc, tail_prev, tail_inc;
  logic          full, empty, ok, vld;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [63:0]   din_ext, dout_ext;

  // limit in force saturates at DEPTH
  function automatic logic is_full_f(input logic [CW-1:0] cnt, input logic [CAP_W-1:0] lim);
    is_full_f = (LW'(cnt) >= LW'(lim)) || (cnt == CW'(DEPTH));
  endfunction

  assign head_prev = (head == '0) ? LAST : head - AW'(1);
  assign head_inc  = (head == LAST) ? '0 : head + AW'(1);
  assign tail_prev = (tail == '0) ? LAST : tail - AW'(1);
  assign tail_inc  = (tail == LAST) ? '0 : tail + AW'(1);

  assign full  = is_full_f(count, cap);
  assign empty = (count == '0);

  assign din_ext  = 64'(data_in);
  assign wdata    = din_ext[DATA_WIDTH-1:0];
  assign dout_ext = 64'(rdata);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    we         = 1'b0;
    waddr      = tail;
    raddr      = head;
    ok         = 1'b0;
    vld        = 1'b0;
    unique case (action)
      ACT_PUSH_FRONT: begin
        if (!full) begin
          head_next  = head_prev;
          waddr      = head_prev;
          we         = 1'b1;
          count_next = count + CW'(1);
          ok         = 1'b1;
        end
      end
      ACT_PUSH_REAR: begin
        if (!full) begin
          tail_next  = tail_inc;
          waddr      = tail;
          we         = 1'b1;
          count_next = count + CW'(1);
          ok         = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (!empty) begin
          head_next  = head_inc;
          count_next = count - CW'(1);
          ok         = 1'b1;
        end
      end
      ACT_POP_REAR: begin
        if (!empty) begin
          tail_next  = tail_prev;
          count_next = count - CW'(1);
          ok         = 1'b1;
        end
      end
      ACT_PEEK_FRONT: begin
        raddr = head;
        ok    = !empty;
        vld   = !empty;
      end
      ACT_PEEK_REAR: begin
        raddr = tail_prev;
        ok    = !empty;
        vld   = !empty;
      end
      default: begin
      end
    endcase
  end

  assign status.peek_hit = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= CAP_RESET;
    end else begin
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (cmd.exec) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // result register; peek data is loaded from the memory's registered read port in the read state
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_success <= ok;
      res_valid   <= vld;
      res_data    <= '0;
      res_empty   <= (count_next == '0);
      res_full    <= is_full_f(count_next, cap);
    end else if (cmd.capture) begin
      res_data <= dout_ext[DIN_W-1:0];
    end
  end

  bdeq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we && cmd.exec),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

/* design/bounded_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque with push/pop/peek at either end and a settable limit.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A push, a pop, a refused action or a peek on
// an empty queue has its result ready in the cycle after the beat is taken; a
// peek that finds data passes through the read state first, for the registered
// read port of the entry memory. The next beat is taken in the cycle after the
// result is handed off. capacity_limit (reset 1024, clamped to DEPTH) may only
// be written while the block is idle; lowering it below the current fill makes
// the queue report full while pops still work.
module bounded_double_ended_queue
  import bdeq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,  // capacity_limit
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,      // [15:0] data_in
  input  logic [2:0]       s_tuser,      // [2:0] action
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,      // [0] success, [16:1] data_out,
                                         // [17] is_empty, [18] is_full
  output logic [0:0]       m_tuser       // [0] data_valid
);

  dp_cmd_t    cmd;
  dp_status_t status;

  logic             res_success, res_valid, res_empty, res_full;
  logic [DIN_W-1:0] res_data;

  bdeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bdeq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .action      (s_tuser),
    .data_in     (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .res_success (res_success),
    .res_data    (res_data),
    .res_valid   (res_valid),
    .res_empty   (res_empty),
    .res_full    (res_full)
  );

  assign m_tdata = {5'b0, res_full, res_empty, res_data, res_success};
  assign m_tuser = res_valid;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for the bounded double-ended queue. A scoreboard
// keeps its own ring buffer and predicts every result beat; the sender and
// receiver idle at random, and the capacity limit is swept between phases.
// ----------------------------------------------------------------------------
import bdeq_pkg::*;

typedef struct packed {
  logic        success;
  logic [15:0] data;
  logic        valid;
  logic        empty;
  logic        full;
} deq_result_t;

localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
localparam int unsigned      RING_SLOTS  = 1024;

class deque_scoreboard;
  logic [15:0]  slot_mem [0:RING_SLOTS-1];
  logic [9:0]   head;
  logic [9:0]   tail;
  int unsigned  fill;
  logic [10:0]  cap;
  deq_result_t  pending [$];
  int unsigned  n_items;
  int unsigned  n_checked;
  int unsigned  n_errors;
  int unsigned  n_refused;
  int unsigned  n_full;
  int unsigned  peak_fill;

  function new();
    head = '0;
    tail = '0;
    fill = 0;
    cap  = CAP_RESET;
  endfunction

  function void set_cap(logic [10:0] v);
    cap = v;
  endfunction

  function int unsigned cap_in_force();
    return (cap > RING_SLOTS) ? RING_SLOTS : cap;
  endfunction

  // Work out the result beat for one accepted input beat.
  function void note_item(logic [2:0] act, logic [15:0] val);
    deq_result_t r;
    bit          at_full;
    bit          at_empty;
    r        = '0;
    at_full  = fill >= cap_in_force();
    at_empty = fill == 0;
    case (act)
      ACT_PUSH_FRONT: if (!at_full) begin
        head = head - 10'd1;
        slot_mem[head] = val;
        fill++;
        r.success = 1'b1;
      end
      ACT_PUSH_REAR: if (!at_full) begin
        slot_mem[tail] = val;
        tail = tail + 10'd1;
        fill++;
        r.success = 1'b1;
      end
      ACT_POP_FRONT: if (!at_empty) begin
        head = head + 10'd1;
        fill--;
        r.success = 1'b1;
      end
      ACT_POP_REAR: if (!at_empty) begin
        tail = tail - 10'd1;
        fill--;
        r.success = 1'b1;
      end
      ACT_PEEK_FRONT: if (!at_empty) begin
        r.data    = slot_mem[head];
        r.success = 1'b1;
        r.valid   = 1'b1;
      end
      ACT_PEEK_REAR: if (!at_empty) begin
        r.data    = slot_mem[tail - 10'd1];
        r.success = 1'b1;
        r.valid   = 1'b1;
      end
      default: ;
    endcase
    if (act <= ACT_POP_REAR && !r.success) n_refused++;
    r.empty = fill == 0;
    r.full  = fill >= cap_in_force();
    if (r.full) n_full++;
    if (fill > peak_fill) peak_fill = fill;
    n_items++;
    pending.insert(pending.size(), r);
  endfunction

  function void report_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch at result %0d: %s expected %h got %h",
                 n_checked, name, exp_v, got_v);
    end
  endfunction

  function void check_result(logic [23:0] td, logic [0:0] tu);
    deq_result_t e;
    if (pending.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("unexpected result beat: tdata %h tuser %h", td, tu);
      return;
    end
    e = pending.pop_front();
    report_field("success",    16'(e.success), 16'(td[0]));
    report_field("data_out",   e.data,         td[16:1]);
    report_field("data_valid", 16'(e.valid),   16'(tu[0]));
    report_field("is_empty",   16'(e.empty),   16'(td[17]));
    report_field("is_full",    16'(e.full),    16'(td[18]));
    n_checked++;
  endfunction
endclass

module tb;

  localparam int IDLE_LIMIT = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata = '0;  // [15:0] data_in
  logic [2:0]       s_tuser = '0;  // [2:0] action
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [23:0]      m_tdata;       // [0] success, [16:1] data_out, [17] is_empty, [18] is_full
  logic [0:0]       m_tuser;       // [0] data_valid

  deque_scoreboard sb = new();
  bit              stall_req = 1'b0;
  int unsigned     idle_cycles = 0;
  int unsigned     tx_calm = 0;

  always #4 clk = ~clk;

  bounded_double_ended_queue u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  // Receiver: checks result beats and throttles m_tready.
  int unsigned rx_hold = 0;
  int unsigned rx_gap  = 0;
  int unsigned rx_calm = 0;
  always @(posedge clk) begin
    int r;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (stall_req && rx_hold == 0) begin
      stall_req = 1'b0;
      rx_hold   = 300;
    end
    r = $urandom_range(0, 99);
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
      m_tready <= 1'b1;
    end else if (r < 2) begin
      rx_calm  = $urandom_range(30, 150);
      m_tready <= 1'b1;
    end else if (r < 60) begin
      m_tready <= 1'b1;
    end else begin
      rx_gap   = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      m_tready <= 1'b0;
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("[bounded_double_ended_queue] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic [2:0] act, input logic [15:0] val);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(act, val);
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (tx_calm > 0) tx_calm--;
    else if (r < 2) tx_calm = $urandom_range(20, 80);
    else if (r >= 55) n = (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic [10:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_cap(v);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [2:0] pick_action(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
    case (r % 4)
      0:       return ACT_POP_FRONT;
      1:       return ACT_POP_REAR;
      2:       return ACT_PEEK_FRONT;
      default: return ACT_PEEK_REAR;
    endcase
  endfunction

  task automatic run_phase(input logic [10:0] cap, input int n, input int push_pct,
                           input bit pressure);
    write_cap(cap);
    for (int i = 0; i < n; i++) begin
      if (pressure && i == 20) stall_req = 1'b1;
      // sender holds off until the queue side has answered everything
      if (pressure && i == n / 2) drain();
      send_beat(pick_action(push_pct), 16'($urandom));
      sender_gap();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue, spare codes, data extremes, both ends
    send_beat(ACT_PEEK_FRONT, 16'h1234);
    send_beat(ACT_PEEK_REAR,  16'hFFFF);
    send_beat(ACT_POP_FRONT,  16'h0000);
    send_beat(ACT_POP_REAR,   16'hFFFF);
    send_beat(ACT_SPARE_6,    16'h0000);
    send_beat(ACT_SPARE_7,    16'hFFFF);
    send_beat(ACT_PUSH_REAR,  16'hFFFF);
    send_beat(ACT_PUSH_FRONT, 16'h0000);  // head wraps below slot 0
    send_beat(ACT_PUSH_REAR,  16'h8001);
    send_beat(ACT_PEEK_FRONT, 16'h0000);
    send_beat(ACT_PEEK_REAR,  16'h0000);
    send_beat(ACT_POP_REAR,   16'h0000);
    send_beat(ACT_PEEK_REAR,  16'h0000);
    send_beat(ACT_POP_FRONT,  16'h0000);
    send_beat(ACT_PEEK_FRONT, 16'h0000);
    send_beat(ACT_POP_FRONT,  16'h0000);
    send_beat(ACT_PEEK_REAR,  16'h0000);
    // single-entry limit
    write_cap(11'd1);
    send_beat(ACT_PUSH_FRONT, 16'h5A5A);
    send_beat(ACT_PUSH_REAR,  16'hA5A5);
    send_beat(ACT_PEEK_REAR,  16'h0000);
    send_beat(ACT_POP_REAR,   16'h0000);
    // zero limit: always full
    write_cap(11'd0);
    send_beat(ACT_PUSH_REAR,  16'h7FFF);
    send_beat(ACT_PEEK_FRONT, 16'h0000);

    run_phase(11'd0,    30,  50, 1'b0);
    run_phase(11'd1,    80,  50, 1'b0);
    run_phase(11'd4,    120, 55, 1'b0);
    run_phase(11'd13,   120, 60, 1'b0);
    // limit above the ring size, pushed until it saturates
    run_phase(11'd2047, 1150, 96, 1'b1);
    // limit far below the current fill: reads full, pops still work
    run_phase(11'd7,    120, 50, 1'b0);
    run_phase(11'd1024, 150, 35, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d actions across limits 0..2047; %0d results checked",
             sb.n_items, sb.n_checked);
    $display("%0d pushes/pops refused, full flag seen %0d times, peak fill %0d",
             sb.n_refused, sb.n_full, sb.peak_fill);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("[bounded_double_ended_queue] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.n_errors, sb.pending.size());
      $display("[bounded_double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule
